// File: rtl/rsie_pkg.sv
// shared types, constants and decode keys for the instruction executor
package rsie_pkg;

   localparam int DATA_WORDS = 32768;
   localparam int PC_WORDS   = 32768;
   localparam int DATA_AW    = $clog2(DATA_WORDS);
   localparam int PC_AW      = $clog2(PC_WORDS);
   localparam int IDX_W      = 15;
   localparam int XLEN       = 32;
   localparam int REG_AW     = 5;
   localparam int REG_COUNT  = 32;

   // two-entry queues between and after the stages
   localparam int QD  = 2;
   localparam int QAW = $clog2(QD);

   localparam logic [1:0] CMD_EXEC    = 2'd0;
   localparam logic [1:0] CMD_PRE_MEM = 2'd1;
   localparam logic [1:0] CMD_PRE_REG = 2'd2;

   localparam logic [1:0] ST_RUN     = 2'd0;
   localparam logic [1:0] ST_HALT    = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;

   localparam logic [6:0]      OPC_LUI  = 7'h37;
   localparam logic [XLEN-1:0] LUI_MASK = 32'hFFFF_F000;

   localparam logic [7:0] KEY_ADD  = 8'd51;
   localparam logic [7:0] KEY_ADDI = 8'd19;
   localparam logic [7:0] KEY_LW   = 8'd5;
   localparam logic [7:0] KEY_SW   = 8'd37;
   localparam logic [7:0] KEY_BEQ  = 8'd99;
   localparam logic [7:0] KEY_BLT  = 8'd103;
   localparam logic [7:0] KEY_LUI  = 8'd55;
   localparam logic [7:0] KEY_HALT = 8'd134;

   typedef enum logic [3:0] {
      K_NOP,
      K_PRE_MEM,
      K_PRE_REG,
      K_ADD,
      K_ADDI,
      K_LW,
      K_SW,
      K_BEQ,
      K_BLT,
      K_LUI,
      K_HALT,
      K_UNKNOWN
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [REG_AW-1:0]   rd;
      logic [REG_AW-1:0]   rs1;
      logic [REG_AW-1:0]   rs2;
      logic [XLEN-1:0]     imm;
      logic [DATA_AW-1:0]  addr;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } issue_type;

   typedef struct packed {
      logic [IDX_W-1:0]  next_pc;
      logic [1:0]        status;
      logic              branch_taken;
      logic              reg_write;
      logic [REG_AW-1:0] reg_index;
      logic [XLEN-1:0]   reg_value;
      logic              mem_write;
      logic [IDX_W-1:0]  mem_index;
   } rsp_type;

endpackage

// File: rtl/rsie_ram.sv
// generic single-write, single-read ram with registered read data
module rsie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/rsie_front.sv
// front end: accepts requests, decodes them and queues them for execution
module rsie_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [1:0]           req_command,
   input  logic [31:0]          req_instruction,
   input  logic [14:0]          req_load_index,
   input  logic [31:0]          req_load_value,
   output rsie_pkg::issue_type  issue,
   input  logic                 issue_pop
);

   // signed divide by four, truncating toward zero
   function automatic logic [rsie_pkg::XLEN-1:0] quarter(input logic [rsie_pkg::XLEN-1:0] v);
      logic [rsie_pkg::XLEN-1:0] neg;
      neg = '0 - v;
      return v[rsie_pkg::XLEN-1] ? ('0 - (neg >> 2)) : (v >> 2);
   endfunction

   rsie_pkg::op_type           dec_op;
   logic [6:0]                 opcode;
   logic [7:0]                 key;
   logic [rsie_pkg::XLEN-1:0]  imm_i;
   logic [rsie_pkg::XLEN-1:0]  imm_s;
   logic [rsie_pkg::XLEN-1:0]  imm_b;
   logic [31:0]                lidx_wide;

   assign opcode    = req_instruction[6:0];
   assign key       = (opcode == rsie_pkg::OPC_LUI) ? {1'b0, opcode}
                                                    : {1'b0, opcode} +
                                                      {5'b0, req_instruction[14:12]};
   assign imm_i     = {{20{req_instruction[31]}}, req_instruction[31:20]};
   assign imm_s     = {{20{req_instruction[31]}}, req_instruction[31:25],
                       req_instruction[11:7]};
   assign imm_b     = {{19{req_instruction[31]}}, req_instruction[31], req_instruction[7],
                       req_instruction[30:25], req_instruction[11:8], 1'b0};
   assign lidx_wide = {17'b0, req_load_index};

   always_comb begin
      dec_op      = '0;
      dec_op.kind = rsie_pkg::K_NOP;
      dec_op.rd   = req_instruction[11:7];
      dec_op.rs1  = req_instruction[19:15];
      dec_op.rs2  = req_instruction[24:20];
      dec_op.addr = lidx_wide[rsie_pkg::DATA_AW-1:0];
      unique case (req_command)
         rsie_pkg::CMD_PRE_MEM: begin
            dec_op.kind = rsie_pkg::K_PRE_MEM;
            dec_op.imm  = req_load_value;
         end
         rsie_pkg::CMD_PRE_REG: begin
            dec_op.rd  = req_load_index[4:0];
            dec_op.imm = req_load_value;
            // registers above 31 and x0 are never written
            if (req_load_index[14:5] == '0 && req_load_index[4:0] != '0) begin
               dec_op.kind = rsie_pkg::K_PRE_REG;
            end
         end
         rsie_pkg::CMD_EXEC: begin
            unique case (key)
               rsie_pkg::KEY_ADD:  dec_op.kind = rsie_pkg::K_ADD;
               rsie_pkg::KEY_ADDI: begin
                  dec_op.kind = rsie_pkg::K_ADDI;
                  dec_op.imm  = imm_i;
               end
               rsie_pkg::KEY_LW: begin
                  dec_op.kind = rsie_pkg::K_LW;
                  dec_op.imm  = quarter(imm_i);
               end
               rsie_pkg::KEY_SW: begin
                  dec_op.kind = rsie_pkg::K_SW;
                  dec_op.imm  = quarter(imm_s);
               end
               rsie_pkg::KEY_BEQ: begin
                  dec_op.kind = rsie_pkg::K_BEQ;
                  dec_op.imm  = quarter(imm_b);
               end
               rsie_pkg::KEY_BLT: begin
                  dec_op.kind = rsie_pkg::K_BLT;
                  dec_op.imm  = quarter(imm_b);
               end
               rsie_pkg::KEY_LUI: begin
                  dec_op.kind = rsie_pkg::K_LUI;
                  dec_op.imm  = req_instruction & rsie_pkg::LUI_MASK;
               end
               rsie_pkg::KEY_HALT: dec_op.kind = rsie_pkg::K_HALT;
               default:            dec_op.kind = rsie_pkg::K_UNKNOWN;
            endcase
         end
         default: dec_op.kind = rsie_pkg::K_NOP;
      endcase
   end

   // decoded request queue
   rsie_pkg::op_type        q_mem_ff [rsie_pkg::QD];
   logic [rsie_pkg::QAW-1:0] q_wr_ptr_ff, q_wr_ptr_in;
   logic [rsie_pkg::QAW-1:0] q_rd_ptr_ff, q_rd_ptr_in;
   logic [rsie_pkg::QAW:0]   q_count_ff, q_count_in;
   logic                     accept;

   assign full   = (q_count_ff == (rsie_pkg::QAW + 1)'(rsie_pkg::QD));
   assign accept = push && !full;

   always_comb begin
      q_wr_ptr_in = accept ? q_wr_ptr_ff + 1'b1 : q_wr_ptr_ff;
      q_rd_ptr_in = issue_pop ? q_rd_ptr_ff + 1'b1 : q_rd_ptr_ff;
      case ({accept, issue_pop})
         2'b10:   q_count_in = q_count_ff + 1'b1;
         2'b01:   q_count_in = q_count_ff - 1'b1;
         default: q_count_in = q_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ptr_ff <= '0;
         q_rd_ptr_ff <= '0;
         q_count_ff  <= '0;
      end else begin
         q_wr_ptr_ff <= q_wr_ptr_in;
         q_rd_ptr_ff <= q_rd_ptr_in;
         q_count_ff  <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_mem_ff[q_wr_ptr_ff] <= dec_op;
      end
   end

   assign issue.valid = (q_count_ff != '0);
   assign issue.op    = q_mem_ff[q_rd_ptr_ff];

endmodule

// File: rtl/rsie_back.sv
// back end: register read, execute, data memory access and result queue
module rsie_back (
   input  logic                 clock,
   input  logic                 reset,
   input  rsie_pkg::issue_type  issue,
   output logic                 issue_pop,
   output logic                 empty,
   input  logic                 pop,
   output rsie_pkg::rsp_type    rsp
);

   localparam int XL = rsie_pkg::XLEN;
   localparam int AW = rsie_pkg::DATA_AW;
   localparam int PW = rsie_pkg::PC_AW;

   // execute stage
   logic                  x_valid_ff, x_valid_in;
   logic                  x_wait_ff, x_wait_in;
   rsie_pkg::op_type      x_op_ff;
   logic                  a_byp_ff, b_byp_ff, a_vld_ff, b_vld_ff;
   logic [XL-1:0]         byp_val_ff;
   logic [rsie_pkg::REG_COUNT-1:0] rf_vld_ff, rf_vld_in;
   logic [PW-1:0]         pc_ff, pc_in, pc_next;
   logic [1:0]            cause_ff, cause_in, cause_next;

   logic                  rf_we;
   logic [rsie_pkg::REG_AW-1:0] rf_waddr;
   logic [XL-1:0]         rf_wdata;
   logic [XL-1:0]         rf_a_rd, rf_b_rd;
   logic                  dm_we, dm_rd_en;
   logic [AW-1:0]         dm_addr;
   logic [XL-1:0]         dm_wdata, dm_rd;

   logic [XL-1:0]         a, b, alu_sum;
   logic [AW-1:0]         ls_addr;
   logic [PW-1:0]         br_target;
   logic                  halted, live, need_wait, out_room, done;
   logic                  reg_wr, mem_wr, taken;
   logic [XL-1:0]         wr_val;
   logic [31:0]           midx_wide, pc_wide;
   rsie_pkg::rsp_type     res;

   rsie_ram #(.WIDTH(XL), .DEPTH(rsie_pkg::REG_COUNT)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_en   (issue_pop),
      .rd_addr (issue.op.rs1),
      .rd_data (rf_a_rd)
   );

   rsie_ram #(.WIDTH(XL), .DEPTH(rsie_pkg::REG_COUNT)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_en   (issue_pop),
      .rd_addr (issue.op.rs2),
      .rd_data (rf_b_rd)
   );

   rsie_ram #(.WIDTH(XL), .DEPTH(rsie_pkg::DATA_WORDS)) u_dmem (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_addr),
      .wr_data (dm_wdata),
      .rd_en   (dm_rd_en),
      .rd_addr (dm_addr),
      .rd_data (dm_rd)
   );

   // never-written registers read as zero; same-cycle writes are bypassed
   assign a = a_byp_ff ? byp_val_ff : (a_vld_ff ? rf_a_rd : '0);
   assign b = b_byp_ff ? byp_val_ff : (b_vld_ff ? rf_b_rd : '0);

   assign alu_sum   = a + ((x_op_ff.kind == rsie_pkg::K_ADD) ? b : x_op_ff.imm);
   assign ls_addr   = a[AW-1:0] + x_op_ff.imm[AW-1:0];
   assign br_target = pc_ff + x_op_ff.imm[PW-1:0];

   assign halted    = (cause_ff != rsie_pkg::ST_RUN);
   assign live      = !halted;
   assign need_wait = (x_op_ff.kind == rsie_pkg::K_LW) && live;

   // result queue
   rsie_pkg::rsp_type        o_mem_ff [rsie_pkg::QD];
   logic [rsie_pkg::QAW-1:0] o_wr_ptr_ff, o_wr_ptr_in;
   logic [rsie_pkg::QAW-1:0] o_rd_ptr_ff, o_rd_ptr_in;
   logic [rsie_pkg::QAW:0]   o_count_ff, o_count_in;
   logic                     o_pop;

   assign out_room  = (o_count_ff != (rsie_pkg::QAW + 1)'(rsie_pkg::QD));
   assign done      = x_valid_ff && (!need_wait || x_wait_ff) && out_room;
   assign issue_pop = issue.valid && (!x_valid_ff || done);

   always_comb begin
      reg_wr     = 1'b0;
      mem_wr     = 1'b0;
      taken      = 1'b0;
      wr_val     = x_op_ff.imm;
      dm_rd_en   = 1'b0;
      dm_addr    = ls_addr;
      dm_wdata   = b;
      pc_next    = pc_ff;
      cause_next = cause_ff;
      case (x_op_ff.kind)
         rsie_pkg::K_PRE_MEM: begin
            dm_addr  = x_op_ff.addr;
            dm_wdata = x_op_ff.imm;
            mem_wr   = 1'b1;
         end
         rsie_pkg::K_PRE_REG: reg_wr = 1'b1;
         rsie_pkg::K_ADD, rsie_pkg::K_ADDI: begin
            reg_wr = live && (x_op_ff.rd != '0);
            wr_val = alu_sum;
         end
         rsie_pkg::K_LUI: reg_wr = live && (x_op_ff.rd != '0);
         rsie_pkg::K_LW: begin
            dm_rd_en = live && !x_wait_ff;
            reg_wr   = live && (x_op_ff.rd != '0);
            wr_val   = dm_rd;
         end
         rsie_pkg::K_SW:  mem_wr = live;
         rsie_pkg::K_BEQ: taken  = live && (a == b);
         rsie_pkg::K_BLT: taken  = live && ($signed(a) < $signed(b));
         rsie_pkg::K_HALT: begin
            if (live) begin
               cause_next = rsie_pkg::ST_HALT;
            end
         end
         rsie_pkg::K_UNKNOWN: begin
            if (live) begin
               cause_next = rsie_pkg::ST_UNKNOWN;
            end
         end
         default: ;
      endcase
      // only live add, addi, lw, sw, beq, blt and lui move the pc; halt, unknown and preloads leave it
      if (live && x_op_ff.kind inside {rsie_pkg::K_ADD, rsie_pkg::K_ADDI, rsie_pkg::K_LW,
                                       rsie_pkg::K_SW, rsie_pkg::K_BEQ, rsie_pkg::K_BLT,
                                       rsie_pkg::K_LUI}) begin
         pc_next = taken ? br_target : pc_ff + 1'b1;
      end
   end

   assign rf_we    = done && reg_wr;
   assign rf_waddr = x_op_ff.rd;
   assign rf_wdata = wr_val;
   assign dm_we    = done && mem_wr;
   assign pc_in    = done ? pc_next : pc_ff;
   assign cause_in = done ? cause_next : cause_ff;
   assign rf_vld_in = rf_vld_ff |
                      (rf_we ? (rsie_pkg::REG_COUNT'(1) << rf_waddr) : '0);

   assign midx_wide = 32'(dm_addr);
   assign pc_wide   = 32'(pc_next);

   always_comb begin
      res.next_pc      = pc_wide[rsie_pkg::IDX_W-1:0];
      res.status       = cause_next;
      res.branch_taken = taken;
      res.reg_write    = reg_wr;
      res.reg_index    = reg_wr ? x_op_ff.rd : '0;
      res.reg_value    = reg_wr ? wr_val : '0;
      res.mem_write    = mem_wr;
      res.mem_index    = mem_wr ? midx_wide[rsie_pkg::IDX_W-1:0] : '0;
   end

   always_comb begin
      x_valid_in = x_valid_ff;
      x_wait_in  = x_wait_ff;
      if (issue_pop) begin
         x_valid_in = 1'b1;
         x_wait_in  = 1'b0;
      end else if (done) begin
         x_valid_in = 1'b0;
         x_wait_in  = 1'b0;
      end else if (x_valid_ff && need_wait) begin
         x_wait_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
         x_wait_ff  <= 1'b0;
         rf_vld_ff  <= '0;
         pc_ff      <= '0;
         cause_ff   <= rsie_pkg::ST_RUN;
      end else begin
         x_valid_ff <= x_valid_in;
         x_wait_ff  <= x_wait_in;
         rf_vld_ff  <= rf_vld_in;
         pc_ff      <= pc_in;
         cause_ff   <= cause_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_pop) begin
         x_op_ff    <= issue.op;
         a_vld_ff   <= rf_vld_ff[issue.op.rs1];
         b_vld_ff   <= rf_vld_ff[issue.op.rs2];
         a_byp_ff   <= rf_we && (rf_waddr == issue.op.rs1);
         b_byp_ff   <= rf_we && (rf_waddr == issue.op.rs2);
         byp_val_ff <= rf_wdata;
      end
   end

   assign o_pop = pop && !empty;

   always_comb begin
      o_wr_ptr_in = done ? o_wr_ptr_ff + 1'b1 : o_wr_ptr_ff;
      o_rd_ptr_in = o_pop ? o_rd_ptr_ff + 1'b1 : o_rd_ptr_ff;
      case ({done, o_pop})
         2'b10:   o_count_in = o_count_ff + 1'b1;
         2'b01:   o_count_in = o_count_ff - 1'b1;
         default: o_count_in = o_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_wr_ptr_ff <= '0;
         o_rd_ptr_ff <= '0;
         o_count_ff  <= '0;
      end else begin
         o_wr_ptr_ff <= o_wr_ptr_in;
         o_rd_ptr_ff <= o_rd_ptr_in;
         o_count_ff  <= o_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         o_mem_ff[o_wr_ptr_ff] <= res;
      end
   end

   assign empty = (o_count_ff == '0);
   assign rsp   = o_mem_ff[o_rd_ptr_ff];

`ifndef ASSERT_OFF
   a_wait_is_load: assert property (@(posedge clock) disable iff (reset)
      x_wait_ff |-> (x_valid_ff && x_op_ff.kind == rsie_pkg::K_LW))
      else $error("load wait phase without a load in execute");

   a_load_two_phase: assert property (@(posedge clock) disable iff (reset)
      (x_valid_ff && need_wait && !x_wait_ff) |=> x_wait_ff)
      else $error("load did not enter its data phase");

   a_halt_pc_holds: assert property (@(posedge clock) disable iff (reset)
      halted |=> $stable(pc_ff))
      else $error("pc moved while halted");

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted |=> $stable(cause_ff))
      else $error("halt cause changed without reset");

   a_x0_never_valid: assert property (@(posedge clock) disable iff (reset)
      rf_we |-> (rf_waddr != '0))
      else $error("write to x0 reached the register file");
`endif

endmodule

// File: rtl/riscv_subset_instruction_executor_top.sv
// top level of the rv32i subset instruction executor
//
// executes add, addi, lw, sw, beq, blt, lui and halt one request at a time
// against an internal word pc, a 32 x 32 register file and a word-addressed
// data memory; preload requests write a data word or a register directly.
// requests enter through push/full and results leave through empty/pop,
// one result per request, in order. a load spends a wait phase in the
// execute stage after its address phase, because the data memory read is
// registered, so the sustained rate is one request per cycle when no load
// or full result queue stalls execute. a request passes through the decode
// queue, leaving it as the register file is read, then through execute
// into the result queue.
// data memory contents are undefined until written; registers read as
// zero after reset. after halt or an unknown instruction, execute requests
// are ignored until reset while preloads still take effect.
module riscv_subset_instruction_executor_top (
   input  logic        clock,
   input  logic        reset,

   // request side
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_instruction,
   input  logic [14:0] req_load_index,
   input  logic [31:0] req_load_value,

   // result side
   output logic        empty,
   input  logic        pop,
   output logic [14:0] rsp_next_pc,
   output logic [1:0]  rsp_status,
   output logic        rsp_branch_taken,
   output logic        rsp_reg_write,
   output logic [4:0]  rsp_reg_index,
   output logic [31:0] rsp_reg_value,
   output logic        rsp_mem_write,
   output logic [14:0] rsp_mem_index
);

   // decoded request handed from front to back
   rsie_pkg::issue_type issue;
   logic                issue_pop;
   rsie_pkg::rsp_type   rsp;

   // front end: decode key, immediates and request queue
   rsie_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_command     (req_command),
      .req_instruction (req_instruction),
      .req_load_index  (req_load_index),
      .req_load_value  (req_load_value),
      .issue           (issue),
      .issue_pop       (issue_pop)
   );

   // back end: register read, execute, memory and result queue
   rsie_back u_back (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .issue_pop (issue_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp       (rsp)
   );

   // result fields out to the ports
   assign rsp_next_pc      = rsp.next_pc;
   assign rsp_status       = rsp.status;
   assign rsp_branch_taken = rsp.branch_taken;
   assign rsp_reg_write    = rsp.reg_write;
   assign rsp_reg_index    = rsp.reg_index;
   assign rsp_reg_value    = rsp.reg_value;
   assign rsp_mem_write    = rsp.mem_write;
   assign rsp_mem_index    = rsp.mem_index;

endmodule
